[rtl/rc4sc_pkg.sv]
// rc4sc_pkg: shared types, codes and constants of the rc4 stream cipher unit
// used by rc4sc_ctrl, rc4sc_datapath and rc4_stream_cipher_unit; no dependencies
`default_nettype none

package rc4sc_pkg;

   localparam int KEY_MAX    = 256;
   localparam int SBOX_DEPTH = 256;
   localparam int BYTE_W     = 8;
   localparam int KEY_CNT_W  = 9;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_NOKEY = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [BYTE_W-1:0] byte_value;
      logic              is_last;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] cipher_byte;
      logic              end_of_message;
      logic              status;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_READ,
      ST_KS_J,
      ST_KS_WR_N,
      ST_KS_WR_J,
      ST_GEN_J,
      ST_GEN_SWAP,
      ST_GEN_OUT,
      ST_NOKEY
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_KEY_LOAD,
      DP_DATA_LOAD,
      DP_INIT,
      DP_KS_READ,
      DP_KS_J,
      DP_KS_WR_N,
      DP_KS_WR_J,
      DP_GEN_J,
      DP_GEN_SWAP,
      DP_GEN_OUT,
      DP_NOKEY_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic keyed;
      logic ctr_last;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/rc4sc_ctrl.sv]
// rc4sc_ctrl: sequencer for key loading, key schedule and keystream generation
// depends on rc4sc_pkg; drives the command word of rc4sc_datapath
`default_nettype none

module rc4sc_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  rc4sc_pkg::req_word_type    req_word,
   input  rc4sc_pkg::dp_status_type   status,
   output rc4sc_pkg::cmd_type         cmd
);

   rc4sc_pkg::state_type state_ff;
   rc4sc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rc4sc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rc4sc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_word.operation == rc4sc_pkg::OP_KEY) begin
                  if (req_word.is_last) begin
                     state_in = rc4sc_pkg::ST_INIT;
                  end
               end else if (status.keyed) begin
                  state_in = rc4sc_pkg::ST_GEN_J;
               end else begin
                  state_in = rc4sc_pkg::ST_NOKEY;
               end
            end
         end
         rc4sc_pkg::ST_INIT: begin
            if (status.ctr_last) begin
               state_in = rc4sc_pkg::ST_KS_READ;
            end
         end
         rc4sc_pkg::ST_KS_READ:  state_in = rc4sc_pkg::ST_KS_J;
         rc4sc_pkg::ST_KS_J:     state_in = rc4sc_pkg::ST_KS_WR_N;
         rc4sc_pkg::ST_KS_WR_N:  state_in = rc4sc_pkg::ST_KS_WR_J;
         rc4sc_pkg::ST_KS_WR_J: begin
            state_in = status.ctr_last ? rc4sc_pkg::ST_IDLE : rc4sc_pkg::ST_KS_READ;
         end
         rc4sc_pkg::ST_GEN_J:    state_in = rc4sc_pkg::ST_GEN_SWAP;
         rc4sc_pkg::ST_GEN_SWAP: state_in = rc4sc_pkg::ST_GEN_OUT;
         rc4sc_pkg::ST_GEN_OUT: begin
            if (status.rsp_free) begin
               state_in = rc4sc_pkg::ST_IDLE;
            end
         end
         rc4sc_pkg::ST_NOKEY: begin
            if (status.rsp_free) begin
               state_in = rc4sc_pkg::ST_IDLE;
            end
         end
         default: state_in = rc4sc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = rc4sc_pkg::DP_NONE;
      case (state_ff)
         rc4sc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = (req_word.operation == rc4sc_pkg::OP_KEY) ?
                        rc4sc_pkg::DP_KEY_LOAD : rc4sc_pkg::DP_DATA_LOAD;
            end
         end
         rc4sc_pkg::ST_INIT:     cmd.op = rc4sc_pkg::DP_INIT;
         rc4sc_pkg::ST_KS_READ:  cmd.op = rc4sc_pkg::DP_KS_READ;
         rc4sc_pkg::ST_KS_J:     cmd.op = rc4sc_pkg::DP_KS_J;
         rc4sc_pkg::ST_KS_WR_N:  cmd.op = rc4sc_pkg::DP_KS_WR_N;
         rc4sc_pkg::ST_KS_WR_J:  cmd.op = rc4sc_pkg::DP_KS_WR_J;
         rc4sc_pkg::ST_GEN_J:    cmd.op = rc4sc_pkg::DP_GEN_J;
         rc4sc_pkg::ST_GEN_SWAP: cmd.op = rc4sc_pkg::DP_GEN_SWAP;
         rc4sc_pkg::ST_GEN_OUT:  cmd.op = rc4sc_pkg::DP_GEN_OUT;
         rc4sc_pkg::ST_NOKEY:    cmd.op = rc4sc_pkg::DP_NOKEY_OUT;
         default:                cmd.op = rc4sc_pkg::DP_NONE;
      endcase
   end

endmodule

`default_nettype wire

[rtl/rc4sc_datapath.sv]
// rc4sc_datapath: key store, s-box memory, indices and result register
// depends on rc4sc_pkg; steered by the command word from rc4sc_ctrl
`default_nettype none

module rc4sc_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  rc4sc_pkg::req_word_type    req_word,
   input  rc4sc_pkg::cmd_type         cmd,
   output rc4sc_pkg::dp_status_type   status,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output rc4sc_pkg::rsp_word_type    rsp_word
);

   localparam int BW = rc4sc_pkg::BYTE_W;
   localparam int CW = rc4sc_pkg::KEY_CNT_W;

   logic [BW-1:0] key_mem [rc4sc_pkg::KEY_MAX];
   logic [BW-1:0] sbox_mem [rc4sc_pkg::SBOX_DEPTH];

   logic [BW-1:0] k_rdata_ff;
   logic [BW-1:0] s_rdata_ff;
   logic [BW-1:0] s_raddr;
   logic [BW-1:0] s_waddr;
   logic [BW-1:0] s_wdata;
   logic          s_we;
   logic          key_we;

   logic          keyed_ff, keyed_in;
   logic [CW-1:0] key_count_ff, key_count_in;
   logic [BW-1:0] i_ff, i_in;
   logic [BW-1:0] j_ff, j_in;
   logic [BW-1:0] ctr_ff, ctr_in;
   logic [BW-1:0] kpos_ff, kpos_in;
   logic [BW-1:0] si_ff, si_in;
   logic [BW-1:0] sj_ff, sj_in;
   logic [BW-1:0] t_ff, t_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rc4sc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic          rsp_free;
   logic [CW-1:0] len_eff;
   logic [CW-1:0] kpos_inc;
   logic [BW-1:0] ks_byte;

   assign rsp_free        = !rsp_valid_ff || rsp_ready;
   assign len_eff         = (key_count_ff == '0) ? CW'(1) : key_count_ff;
   assign kpos_inc        = {1'b0, kpos_ff} + CW'(1);
   assign status.keyed    = keyed_ff;
   assign status.ctr_last = (ctr_ff == '1);
   assign status.rsp_free = rsp_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;

   // swap forwarding for the final keystream lookup
   always_comb begin
      if (t_ff == j_ff) begin
         ks_byte = si_ff;
      end else if (t_ff == i_ff) begin
         ks_byte = sj_ff;
      end else begin
         ks_byte = s_rdata_ff;
      end
   end

   always_comb begin
      keyed_in     = keyed_ff;
      key_count_in = key_count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      ctr_in       = ctr_ff;
      kpos_in      = kpos_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_we       = 1'b0;
      s_we         = 1'b0;
      s_waddr      = ctr_ff;
      s_wdata      = ctr_ff;
      s_raddr      = i_ff + BW'(1);
      case (cmd.op)
         rc4sc_pkg::DP_KEY_LOAD: begin
            keyed_in = 1'b0;
            if (key_count_ff < CW'(rc4sc_pkg::KEY_MAX)) begin
               key_we       = 1'b1;
               key_count_in = key_count_ff + CW'(1);
            end
            if (req_word.is_last) begin
               ctr_in  = '0;
               kpos_in = '0;
               j_in    = '0;
            end
         end
         rc4sc_pkg::DP_DATA_LOAD: begin
            byte_in = req_word.byte_value;
            last_in = req_word.is_last;
            if (keyed_ff) begin
               i_in = i_ff + BW'(1);
               if (req_word.is_last) begin
                  keyed_in     = 1'b0;
                  key_count_in = '0;
               end
            end
         end
         rc4sc_pkg::DP_INIT: begin
            s_we   = 1'b1;
            ctr_in = ctr_ff + BW'(1);
         end
         rc4sc_pkg::DP_KS_READ: begin
            s_raddr = ctr_ff;
         end
         rc4sc_pkg::DP_KS_J: begin
            si_in   = s_rdata_ff;
            j_in    = j_ff + s_rdata_ff + k_rdata_ff;
            s_raddr = j_ff + s_rdata_ff + k_rdata_ff;
         end
         rc4sc_pkg::DP_KS_WR_N: begin
            s_we    = 1'b1;
            s_wdata = s_rdata_ff;
         end
         rc4sc_pkg::DP_KS_WR_J: begin
            s_we    = 1'b1;
            s_waddr = j_ff;
            s_wdata = si_ff;
            ctr_in  = ctr_ff + BW'(1);
            kpos_in = (kpos_inc >= len_eff) ? '0 : kpos_inc[BW-1:0];
            if (ctr_ff == '1) begin
               keyed_in     = 1'b1;
               key_count_in = '0;
               i_in         = '0;
               j_in         = '0;
            end
         end
         rc4sc_pkg::DP_GEN_J: begin
            si_in   = s_rdata_ff;
            j_in    = j_ff + s_rdata_ff;
            s_raddr = j_ff + s_rdata_ff;
         end
         rc4sc_pkg::DP_GEN_SWAP: begin
            s_we    = 1'b1;
            s_waddr = i_ff;
            s_wdata = s_rdata_ff;
            sj_in   = s_rdata_ff;
            s_raddr = si_ff + s_rdata_ff;
            t_in    = si_ff + s_rdata_ff;
         end
         rc4sc_pkg::DP_GEN_OUT: begin
            s_we    = 1'b1;
            s_waddr = j_ff;
            s_wdata = si_ff;
            s_raddr = t_ff;
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.cipher_byte    = byte_ff ^ ks_byte;
               rsp_word_in.end_of_message = last_ff;
               rsp_word_in.status         = rc4sc_pkg::STATUS_OK;
            end
         end
         rc4sc_pkg::DP_NOKEY_OUT: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_word_in.cipher_byte    = '0;
               rsp_word_in.end_of_message = last_ff;
               rsp_word_in.status         = rc4sc_pkg::STATUS_NOKEY;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_count_ff[BW-1:0]] <= req_word.byte_value;
      end
      k_rdata_ff <= key_mem[kpos_ff];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sbox_mem[s_waddr] <= s_wdata;
      end
      s_rdata_ff <= sbox_mem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keyed_ff     <= 1'b0;
         key_count_ff <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         ctr_ff       <= '0;
         kpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         keyed_ff     <= keyed_in;
         key_count_ff <= key_count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         ctr_ff       <= ctr_in;
         kpos_ff      <= kpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_sched_end_keyed: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rc4sc_pkg::DP_KS_WR_J && ctr_ff == '1)
      |=> (keyed_ff && key_count_ff == '0 && i_ff == '0 && j_ff == '0))
      else $error("key schedule did not leave the generator ready");

   a_gen_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rc4sc_pkg::DP_GEN_OUT && !rsp_free)
      |=> ($stable(t_ff) && $stable(si_ff) && $stable(byte_ff)))
      else $error("generator operands changed while the result waits");

   a_i_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rc4sc_pkg::DP_DATA_LOAD && keyed_ff)
      |=> (i_ff == $past(i_ff) + BW'(1)))
      else $error("index i did not advance for a keyed data word");

   a_key_count_cap: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rc4sc_pkg::DP_KEY_LOAD)
      |=> (key_count_ff <= CW'(rc4sc_pkg::KEY_MAX) && !keyed_ff))
      else $error("key load left a bad count or a stale key");

endmodule

`default_nettype wire

[rtl/rc4_stream_cipher_unit.sv]
// rc4_stream_cipher_unit: top level of the rc4 stream cipher
// depends on rc4sc_pkg, rc4sc_ctrl and rc4sc_datapath
//
// usage
//   req channel: one word per key byte (operation = key) or data byte
//   (operation = data); is_last marks the final key byte or message byte
//   rsp channel: one word per data byte, none per key byte
//   key byte: taken while idle; the last key byte starts the key schedule,
//   an s-box fill of every entry, then a read, read, write, write swap step
//   per entry, during which req_ready is low
//   keyed data byte: result registered in gen_out, after gen_j and gen_swap,
//   the states of the s-box reads and writes; no new byte is taken until
//   gen_out is left; the s-box memory has one read and one write port
//   data byte before a key: result with status set, registered in the nokey state
//   reset: not keyed, key count and indices cleared, no result pending
//   rsp stall: a new word is still taken while a result waits; the next
//   result holds in its last stage until the output register frees up
`default_nettype none

module rc4_stream_cipher_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  rc4sc_pkg::req_word_type  req_word,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output rc4sc_pkg::rsp_word_type  rsp_word
);

   rc4sc_pkg::cmd_type       cmd;
   rc4sc_pkg::dp_status_type status;

   rc4sc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .status    (status),
      .cmd       (cmd)
   );

   rc4sc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
